// File: rtl/core/acpr_pkg.sv
// shared widths, field offsets and test-unit result type for the range-to-prefix block
package acpr_pkg;

    // default address width of the range arithmetic
    localparam int DEF_ADDR_BITS = 32;

    // fixed field widths of the stream payloads
    localparam int FIELD_ADDR_W = 32;
    localparam int LEN_W        = 6;

    // input tdata layout: lower_addr, lower_len, upper_addr, upper_len, padded to bytes
    localparam int IN_LO_ADDR_LSB = 0;
    localparam int IN_LO_LEN_LSB  = IN_LO_ADDR_LSB + FIELD_ADDR_W;
    localparam int IN_HI_ADDR_LSB = IN_LO_LEN_LSB + LEN_W;
    localparam int IN_HI_LEN_LSB  = IN_HI_ADDR_LSB + FIELD_ADDR_W;
    localparam int IN_USED_W      = IN_HI_LEN_LSB + LEN_W;
    localparam int IN_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout: prefix_addr, prefix_len, padded to bytes
    localparam int OUT_USED_W     = FIELD_ADDR_W + LEN_W;
    localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    // result of one block test at a candidate prefix size
    typedef struct packed {
        logic fit;        // block is aligned and stays within the range end
        logic reach_end;  // block ends exactly at the range end
    } t_test_res;

endpackage

// File: rtl/core/acpr_test_unit.sv
// shared block test: alignment of the current address and fit below the range end
module acpr_test_unit
    import acpr_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  logic [ADDR_BITS-1:0]             i_cur,
    input  logic [ADDR_BITS-1:0]             i_hi,
    input  logic [$clog2(ADDR_BITS+1)-1:0]   i_k,
    output t_test_res                        o_res,
    output logic [ADDR_BITS-1:0]             o_top
);

    localparam int KW = $clog2(ADDR_BITS + 1);

    logic [ADDR_BITS-1:0] w_mask;
    logic                 w_aligned;

    // low k bits set: host part of a block of 2^k addresses
    always_comb begin
        for (int i = 0; i < ADDR_BITS; i++) begin
            w_mask[i] = (KW'(i) < i_k);
        end
    end

    // aligned block tops out at cur | mask, so a plain compare checks the fit
    assign w_aligned       = ((i_cur & w_mask) == '0);
    assign o_top           = i_cur | w_mask;
    assign o_res.fit       = w_aligned && (o_top <= i_hi);
    assign o_res.reach_end = (o_top == i_hi);

endmodule

// File: rtl/core/address_range_to_cidr_prefixes.sv
// address range to cidr prefix decomposition, top level with sequencer
//
//  channel   dir  handshake                 payload
//  s         in   i_s_tvalid / o_s_tready   tdata: lower_addr, lower_len, upper_addr, upper_len
//  m         out  o_m_tvalid / i_m_tready   tdata: prefix_addr, prefix_len; tlast: last;
//                                           tuser: status
//
//  one input transaction takes a load step, an emit and a re-check per emitted prefix
//  and one step of the prefix-size search per candidate size tried.
//  the search walks one candidate size per cycle through the single shared block-test unit.
//  an empty range gives one error transaction, valid in the cycle after the load cycle.
//  i_rst_n is synchronous, active low, and returns the block to idle.
//  o_s_tready is high only while idle; a stalled output holds its transaction.
module address_range_to_cidr_prefixes
    import acpr_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [31:0] lower_addr, [37:32] lower_len, [69:38] upper_addr, [75:70] upper_len, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [31:0] prefix_addr, [37:32] prefix_len, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast,
    // [0] status
    output logic                   o_m_tuser
);

    localparam int KW = $clog2(ADDR_BITS + 1);
    localparam logic [KW-1:0]    K_MAX = KW'(ADDR_BITS);
    localparam logic [LEN_W-1:0] W_LEN = LEN_W'(ADDR_BITS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_UP    = 6'b000100,
        S_CHECK = 6'b001000,
        S_DOWN  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [ADDR_BITS-1:0] r_cur, n_cur;
    logic [ADDR_BITS-1:0] r_hi, n_hi;
    logic [KW-1:0]        r_k, n_k;
    logic                 r_reach, n_reach;
    logic                 r_err, n_err;

    logic [FIELD_ADDR_W-1:0]        w_lo_addr, w_hi_addr;
    logic [LEN_W-1:0]               w_lo_len, w_hi_len;
    logic [LEN_W-1:0]               w_lo_sat, w_hi_sat, w_lo_host, w_hi_host;
    logic [ADDR_BITS-1:0]           w_lo_mask, w_hi_mask;
    logic [ADDR_BITS+FIELD_ADDR_W-1:0] w_lo_pad, w_hi_pad, w_cur_pad;
    logic [ADDR_BITS-1:0]           w_lo, w_hi;
    logic [KW-1:0]                  w_test_k;
    t_test_res                      w_res;
    logic [ADDR_BITS-1:0]           w_top;
    logic [FIELD_ADDR_W-1:0]        w_out_addr;
    logic [LEN_W-1:0]               w_out_len;

    // unpack the input transaction
    assign w_lo_addr = i_s_tdata[IN_LO_ADDR_LSB +: FIELD_ADDR_W];
    assign w_lo_len  = i_s_tdata[IN_LO_LEN_LSB  +: LEN_W];
    assign w_hi_addr = i_s_tdata[IN_HI_ADDR_LSB +: FIELD_ADDR_W];
    assign w_hi_len  = i_s_tdata[IN_HI_LEN_LSB  +: LEN_W];

    // saturate mask lengths and form host masks
    assign w_lo_sat  = (w_lo_len > W_LEN) ? W_LEN : w_lo_len;
    assign w_hi_sat  = (w_hi_len > W_LEN) ? W_LEN : w_hi_len;
    assign w_lo_host = W_LEN - w_lo_sat;
    assign w_hi_host = W_LEN - w_hi_sat;

    always_comb begin
        for (int i = 0; i < ADDR_BITS; i++) begin
            w_lo_mask[i] = (LEN_W'(i) < w_lo_host);
            w_hi_mask[i] = (LEN_W'(i) < w_hi_host);
        end
    end

    // range start is the network address, range end the broadcast address
    assign w_lo_pad = {{ADDR_BITS{1'b0}}, w_lo_addr};
    assign w_hi_pad = {{ADDR_BITS{1'b0}}, w_hi_addr};
    assign w_lo     = w_lo_pad[ADDR_BITS-1:0] & ~w_lo_mask;
    assign w_hi     = w_hi_pad[ADDR_BITS-1:0] | w_hi_mask;

    // candidate size fed to the shared test unit
    always_comb begin
        case (r_state)
            S_LOAD:  w_test_k = '0;
            S_UP:    w_test_k = r_k + KW'(1);
            default: w_test_k = r_k;
        endcase
    end

    acpr_test_unit #(
        .ADDR_BITS (ADDR_BITS)
    ) u_test (
        .i_cur (r_cur),
        .i_hi  (r_hi),
        .i_k   (w_test_k),
        .o_res (w_res),
        .o_top (w_top)
    );

    // sequencer: grow the block size, emit, then re-check and shrink as needed
    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_hi    = r_hi;
        n_k     = r_k;
        n_reach = r_reach;
        n_err   = r_err;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cur   = w_lo;
                    n_hi    = w_hi;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_k = '0;
                if (w_res.fit) begin
                    n_err   = 1'b0;
                    n_reach = w_res.reach_end;
                    n_state = S_UP;
                end else begin
                    // start above end: empty range
                    n_err   = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_UP: begin
                if (r_k == K_MAX) begin
                    n_state = S_EMIT;
                end else if (w_res.fit) begin
                    n_k     = r_k + KW'(1);
                    n_reach = w_res.reach_end;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_CHECK: begin
                if (w_res.fit) begin
                    n_reach = w_res.reach_end;
                    n_state = S_UP;
                end else begin
                    n_k     = r_k - KW'(1);
                    n_state = S_DOWN;
                end
            end
            S_DOWN: begin
                if (w_res.fit) begin
                    n_reach = w_res.reach_end;
                    n_state = S_EMIT;
                end else begin
                    n_k = r_k - KW'(1);
                end
            end
            S_EMIT: begin
                if (i_m_tready) begin
                    if (r_err || r_reach) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur   = w_top + ADDR_BITS'(1);
                        n_state = S_CHECK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_hi    <= n_hi;
        r_k     <= n_k;
        r_reach <= n_reach;
        r_err   <= n_err;
    end

    // output transaction
    assign w_cur_pad  = {{FIELD_ADDR_W{1'b0}}, r_cur};
    assign w_out_addr = r_err ? '0 : w_cur_pad[FIELD_ADDR_W-1:0];
    assign w_out_len  = r_err ? '0 : (W_LEN - LEN_W'(r_k));

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_EMIT);
    assign o_m_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, w_out_len, w_out_addr};
    assign o_m_tlast  = r_err | r_reach;
    assign o_m_tuser  = r_err;

    // input and output sides are never open together
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while a result is pending");

    // an error transaction is a single last result with zero fields
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && (o_m_tdata == '0)))
        else $error("error result not last or not zeroed");

    // the emitted block never starts past the range end
    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_err) |-> (r_cur <= r_hi))
        else $error("prefix start beyond range end");

    // size never exceeds the address width
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_LOAD) |-> (r_k <= K_MAX))
        else $error("prefix size out of range");

    // taking the last result frees the input side
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("block not idle after last result");

endmodule

// File: tb/sv/address_range_to_cidr_prefixes_tb.sv
// self-checking testbench for the address range to cidr prefix decomposition block
module address_range_to_cidr_prefixes_tb;
    import acpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W        = DEF_ADDR_BITS;
    localparam int IDLE_LIMIT    = 4000;
    localparam int LONG_HOLD     = 600;
    localparam int HOLD_AT_RANGE = 60;
    localparam int QUIET_TAIL    = 40;
    localparam int END_CYCLES    = 250;

    // one input transaction: two prefixes bounding the range
    typedef struct {
        bit [31:0] lower_addr;
        bit [5:0]  lower_len;
        bit [31:0] upper_addr;
        bit [5:0]  upper_len;
        bit        wait_idle;  // hold back until all prior prefixes are out
    } t_range_req;

    // one output transaction
    typedef struct {
        bit [31:0] addr;
        bit [5:0]  len;
        bit        last;
        bit        status;
    } t_prefix;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;

    t_range_req pending_ranges[$];
    t_prefix    expected_prefixes[$];
    int         mismatch_cnt = 0;
    int         ranges_sent = 0;
    int         prefixes_seen = 0;

    address_range_to_cidr_prefixes dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    // clock
    initial begin
        forever #6 clk = ~clk;
    end

    function automatic bit quiet_phase();
        return pending_ranges.size() < QUIET_TAIL;
    endfunction

    // host part of a prefix, length saturated at the address width
    function automatic bit [63:0] host_bits(input bit [5:0] len);
        int l;
        l = (len > ADDR_W) ? ADDR_W : int'(len);
        return (64'd1 << (ADDR_W - l)) - 64'd1;
    endfunction

    // largest aligned block walk from the range start up to the range end
    task automatic predict_prefixes(input t_range_req r);
        bit [63:0] lo;
        bit [63:0] hi;
        bit [63:0] cur;
        bit [63:0] blk_end;
        bit [63:0] sz;
        int        k;
        t_prefix   p;
        lo = {32'd0, r.lower_addr} & ~host_bits(r.lower_len) & ((64'd1 << ADDR_W) - 64'd1);
        hi = {32'd0, r.upper_addr} | host_bits(r.upper_len);
        if (lo > hi) begin
            p.addr   = '0;
            p.len    = '0;
            p.last   = 1'b1;
            p.status = 1'b1;
            expected_prefixes.push_back(p);
            return;
        end
        cur = lo;
        forever begin
            k = ADDR_W;
            while (k > 0) begin
                sz = 64'd1 << k;
                if ((cur & (sz - 64'd1)) == 64'd0 && cur + sz - 64'd1 <= hi)
                    break;
                k--;
            end
            blk_end  = cur + (64'd1 << k) - 64'd1;
            p.addr   = cur[31:0];
            p.len    = 6'(ADDR_W - k);
            p.last   = (blk_end >= hi);
            p.status = 1'b0;
            expected_prefixes.push_back(p);
            if (p.last)
                break;
            cur = blk_end + 64'd1;
        end
    endtask

    function automatic logic [IN_TDATA_W-1:0] pack_range(input t_range_req r);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[IN_LO_ADDR_LSB +: FIELD_ADDR_W] = r.lower_addr;
        d[IN_LO_LEN_LSB +: LEN_W]         = r.lower_len;
        d[IN_HI_ADDR_LSB +: FIELD_ADDR_W] = r.upper_addr;
        d[IN_HI_LEN_LSB +: LEN_W]         = r.upper_len;
        return d;
    endfunction

    task automatic add_range(input bit [31:0] la, input bit [5:0] ll,
                             input bit [31:0] ua, input bit [5:0] ul, input bit hold);
        t_range_req r;
        r.lower_addr = la;
        r.lower_len  = ll;
        r.upper_addr = ua;
        r.upper_len  = ul;
        r.wait_idle  = hold;
        pending_ranges.push_back(r);
    endtask

    // mostly realistic lengths, some past the address width
    function automatic bit [5:0] pick_len();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return 6'($urandom_range(0, 32));
        else if (sel < 9)
            return 6'($urandom_range(20, 32));
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic add_random_range(input bit hold);
        bit [31:0] a;
        bit [31:0] b;
        bit [31:0] t;
        bit [32:0] sum;
        int        kind;
        kind = $urandom_range(0, 9);
        a = $urandom;
        b = $urandom;
        if (kind <= 5) begin
            // ordered bounds with arbitrary lengths
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            add_range(a, pick_len(), b, pick_len(), hold);
        end else if (kind == 6) begin
            // short span, long prefixes
            sum = {1'b0, a} + 33'($urandom_range(0, 1 << $urandom_range(0, 20)));
            b = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            add_range(a, 6'($urandom_range(26, 32)), b, 6'($urandom_range(26, 32)), hold);
        end else if (kind == 7) begin
            // start above end
            a = a | 32'h0000_0100;
            b = a - 32'($urandom_range(1, 255));
            add_range(a, 6'($urandom_range(32, 63)), b, 6'($urandom_range(32, 63)), hold);
        end else begin
            add_range(a, 6'($urandom_range(0, 63)), b, 6'($urandom_range(0, 63)), hold);
        end
    endtask

    task automatic report(input string what);
        $display("[%0t] prefix %0d: %s", $realtime, prefixes_seen, what);
        mismatch_cnt++;
    endtask

    // range transaction driver
    always @(posedge clk) begin : drive_ranges
        bit offer;
        int send_gap;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_prefixes(pending_ranges[0]);
                void'(pending_ranges.pop_front());
                ranges_sent++;
                if (!quiet_phase() && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 10);
            end
            if (s_tvalid && !s_tready)
                offer = 1'b1;
            else if (send_gap > 0) begin
                send_gap--;
                offer = 1'b0;
            end else if (pending_ranges.size() == 0)
                offer = 1'b0;
            else if (pending_ranges[0].wait_idle && expected_prefixes.size() != 0)
                offer = 1'b0;
            else
                offer = 1'b1;
            s_tvalid <= offer;
            if (offer)
                s_tdata <= pack_range(pending_ranges[0]);
        end
    end

    // output backpressure, with one long hold to fill the block
    always @(posedge clk) begin : drive_ready
        int ready_gap;
        int hold_left;
        bit hold_done;
        if (!rst_n) begin
            m_tready <= 1'b0;
            ready_gap = 0;
            hold_left = 0;
        end else begin
            if (!hold_done && ranges_sent >= HOLD_AT_RANGE) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_tready <= 1'b0;
            end else if (!quiet_phase() && $urandom_range(0, 7) == 0) begin
                ready_gap = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare each prefix transaction with the oldest prediction
    always @(posedge clk) begin : check_prefixes
        t_prefix want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_prefixes.size() == 0) begin
                report($sformatf("unexpected result %h/%0d", m_tdata[FIELD_ADDR_W-1:0],
                                 m_tdata[FIELD_ADDR_W +: LEN_W]));
            end else begin
                want = expected_prefixes.pop_front();
                if (m_tdata[FIELD_ADDR_W-1:0] !== want.addr)
                    report($sformatf("prefix_addr %h, want %h",
                                     m_tdata[FIELD_ADDR_W-1:0], want.addr));
                if (m_tdata[FIELD_ADDR_W +: LEN_W] !== want.len)
                    report($sformatf("prefix_len %0d, want %0d",
                                     m_tdata[FIELD_ADDR_W +: LEN_W], want.len));
                if (m_tlast !== want.last)
                    report($sformatf("last %b, want %b", m_tlast, want.last));
                if (m_tuser !== want.status)
                    report($sformatf("status %b, want %b", m_tuser, want.status));
            end
            prefixes_seen++;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk) begin : watchdog
        int idle_cycles;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        // whole address space, address bits under a /0 ignored
        add_range(32'h0000_0000, 6'd0, 32'h0000_0000, 6'd0, 1'b0);
        add_range(32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF, 6'd0, 1'b0);
        add_range(32'h0000_0000, 6'd32, 32'hFFFF_FFFF, 6'd32, 1'b0);
        // worst case fragmentation
        add_range(32'h0000_0001, 6'd32, 32'hFFFF_FFFE, 6'd32, 1'b0);
        add_range(32'h0000_0001, 6'd32, 32'hFFFF_FFFF, 6'd32, 1'b0);
        add_range(32'h0000_0000, 6'd32, 32'hFFFF_FFFE, 6'd32, 1'b0);
        // single aligned blocks
        add_range(32'h0A00_0000, 6'd8, 32'h0AFF_FFFF, 6'd8, 1'b0);
        add_range(32'h0A00_0001, 6'd24, 32'h0A00_01FF, 6'd24, 1'b0);
        add_range(32'h0000_0000, 6'd32, 32'h7FFF_FFFF, 6'd32, 1'b0);
        add_range(32'h8000_0000, 6'd1, 32'hFFFF_FFFF, 6'd1, 1'b0);
        // host prefixes at both ends of the space
        add_range(32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 6'd32, 1'b0);
        add_range(32'h0000_0000, 6'd32, 32'h0000_0000, 6'd32, 1'b0);
        // empty ranges
        add_range(32'h0A00_0001, 6'd32, 32'h0A00_0000, 6'd32, 1'b0);
        add_range(32'hC000_0000, 6'd2, 32'h8000_0000, 6'd2, 1'b0);
        add_range(32'hFFFF_FFFF, 6'd63, 32'h0000_0000, 6'd63, 1'b0);
        // lengths past the address width saturate to host prefixes
        add_range(32'h1234_5678, 6'd33, 32'h1234_5678, 6'd63, 1'b0);
        add_range(32'h8765_4321, 6'd63, 32'h8765_4400, 6'd0, 1'b0);
        add_range(32'h5555_5555, 6'd42, 32'hAAAA_AAAA, 6'd21, 1'b0);
        add_range(32'hAAAA_AAAA, 6'd63, 32'h5555_5555, 6'd0, 1'b0);
        add_range(32'hAAAA_AAAA, 6'd21, 32'h5555_5555, 6'd42, 1'b0);
        // random part, twice waiting for the block to drain first
        for (int i = 0; i < 450; i++)
            add_random_range(i == 5 || i == 300);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ranges.size() > 0)
            @(posedge clk);
        while (expected_prefixes.size() > 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/core/acpr_pkg.sv
rtl/core/acpr_test_unit.sv
rtl/core/address_range_to_cidr_prefixes.sv
tb/sv/address_range_to_cidr_prefixes_tb.sv
